FILE: hw/rtl/snset_pkg.sv
// ----------------------------------------------------------------------------
// snset_pkg
// Shared types and constants for the sorted note set block.
// ----------------------------------------------------------------------------
package snset_pkg;

    localparam int NOTE_SLOTS = 32;
    localparam int CHANNELS   = 16;
    localparam int PITCH_BITS = 16;
    localparam int CH_W       = $clog2(CHANNELS);
    localparam int SLOT_W     = $clog2(NOTE_SLOTS);
    localparam int LINK_W     = SLOT_W + 1;

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NOTE_SLOTS);

    localparam logic [1:0] CMD_ON    = 2'd0;
    localparam logic [1:0] CMD_OFF   = 2'd1;
    localparam logic [1:0] CMD_ALL   = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_BEGIN = 2'd1;
    localparam logic [1:0] EV_END   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ALREADY = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [1:0]                   cmd;
        logic [CH_W-1:0]              channel;
        logic signed [PITCH_BITS-1:0] pitch;
    } t_req;

    typedef struct packed {
        logic [1:0]                   event_res;
        logic [1:0]                   status;
        logic signed [PITCH_BITS-1:0] note_pitch_out;
        logic [SLOT_W-1:0]            slot;
        logic                         is_on;
        logic                         last;
    } t_res;

    function automatic logic link_ok(input logic [LINK_W-1:0] l);
        link_ok = (l < LINK_NONE);
    endfunction

endpackage

FILE: hw/rtl/sorted_note_set_per_channel.sv
// ----------------------------------------------------------------------------
// sorted_note_set_per_channel
// Per-channel pitch-sorted note lists in a shared pool of note slots.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request walks its channel's list one
// linked slot per cycle through the pitch/next/prev RAMs (one read port
// each, registered read data), visiting at most 32 notes; an insert that
// patches a neighbor also passes through S_LINK. all notes off gives one
// result per cycle while the output is not stalled. The result register
// lets the next request enter while the last result still waits.
module sorted_note_set_per_channel (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  snset_pkg::t_req   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output snset_pkg::t_res   o_out_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_LINK = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    localparam int SW = snset_pkg::SLOT_W;
    localparam int LW = snset_pkg::LINK_W;
    localparam int PW = snset_pkg::PITCH_BITS;

    logic [2:0]  r_state, n_state;
    logic [1:0]  r_cmd;
    logic [snset_pkg::CH_W-1:0] r_ch;
    logic [PW-1:0] r_p;
    logic [LW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_head [snset_pkg::CHANNELS];
    logic [snset_pkg::NOTE_SLOTS-1:0] r_used, n_used;
    logic [LW-1:0] r_ns, n_ns;
    logic [LW-1:0] r_cnext, n_cnext;
    logic [LW-1:0] r_cprev, n_cprev;
    logic          r_before, n_before;
    snset_pkg::t_res r_res, n_res;
    logic            r_ovalid, n_ovalid;
    snset_pkg::t_res r_out, n_out;

    logic          head_we;
    logic [LW-1:0] head_wdata;

    logic          rd_en;
    logic [SW-1:0] rd_addr;
    logic          p_we, n_we, v_we;
    logic [SW-1:0] p_wa, n_wa, v_wa;
    logic [PW-1:0] p_wd;
    logic [LW-1:0] n_wd, v_wd;
    logic [PW-1:0] q_pitch;
    logic [LW-1:0] q_next, q_prev;

    logic          out_free;
    logic          free_any;
    logic [SW-1:0] free_idx;
    logic          hit;
    logic          p_less;

    snset_ram #(.WIDTH(PW), .DEPTH(snset_pkg::NOTE_SLOTS)) u_pitch (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_re(rd_en), .i_raddr(rd_addr), .o_rdata(q_pitch)
    );
    snset_ram #(.WIDTH(LW), .DEPTH(snset_pkg::NOTE_SLOTS)) u_next (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(n_wa), .i_wdata(n_wd),
        .i_re(rd_en), .i_raddr(rd_addr), .o_rdata(q_next)
    );
    snset_ram #(.WIDTH(LW), .DEPTH(snset_pkg::NOTE_SLOTS)) u_prev (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_wa), .i_wdata(v_wd),
        .i_re(rd_en), .i_raddr(rd_addr), .o_rdata(q_prev)
    );

    // lowest free slot
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = snset_pkg::NOTE_SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_any = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    assign out_free = !r_ovalid || !i_out_stall;
    assign hit      = (q_pitch == r_p);
    assign p_less   = ($signed(r_p) < $signed(q_pitch));

    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_used   = r_used;
        n_ns     = r_ns;
        n_cnext  = r_cnext;
        n_cprev  = r_cprev;
        n_before = r_before;
        n_res    = r_res;
        n_ovalid = r_ovalid && i_out_stall;
        n_out    = r_out;
        head_we    = 1'b0;
        head_wdata = r_cur;
        rd_en   = 1'b0;
        rd_addr = r_cur[SW-1:0];
        p_we = 1'b0; p_wa = r_ns[SW-1:0]; p_wd = r_p;
        n_we = 1'b0; n_wa = r_ns[SW-1:0]; n_wd = snset_pkg::LINK_NONE;
        v_we = 1'b0; v_wa = r_ns[SW-1:0]; v_wd = snset_pkg::LINK_NONE;

        n_res.note_pitch_out = r_p;
        n_res.last           = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cur   = r_head[i_in_data.channel];
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (snset_pkg::link_ok(r_cur)) begin
                    rd_en   = 1'b1;
                    n_state = S_CHK;
                end else begin
                    n_state = S_EMIT;
                    n_res.event_res = snset_pkg::EV_NONE;
                    n_res.slot      = '0;
                    n_res.is_on     = 1'b0;
                    case (r_cmd)
                        snset_pkg::CMD_ON: begin
                            if (!free_any) begin
                                n_res.status = snset_pkg::ST_FULL;
                            end else begin
                                p_we = 1'b1; n_we = 1'b1; v_we = 1'b1;
                                p_wa = free_idx; n_wa = free_idx; v_wa = free_idx;
                                head_we    = 1'b1;
                                head_wdata = {1'b0, free_idx};
                                n_used[free_idx] = 1'b1;
                                n_res.event_res = snset_pkg::EV_BEGIN;
                                n_res.status    = snset_pkg::ST_OK;
                                n_res.slot      = free_idx;
                                n_res.is_on     = 1'b1;
                            end
                        end
                        snset_pkg::CMD_ALL: begin
                            n_res.status = snset_pkg::ST_OK;
                        end
                        default: begin
                            n_res.status = snset_pkg::ST_NOTFOUND;
                        end
                    endcase
                end
            end
            S_CHK: begin
                n_res.slot  = r_cur[SW-1:0];
                n_res.event_res = snset_pkg::EV_NONE;
                n_res.status    = snset_pkg::ST_OK;
                n_res.is_on     = 1'b0;
                case (r_cmd)
                    snset_pkg::CMD_ON: begin
                        if (hit) begin
                            n_res.status = snset_pkg::ST_ALREADY;
                            n_res.is_on  = 1'b1;
                            n_state      = S_EMIT;
                        end else if (!snset_pkg::link_ok(q_next) || p_less) begin
                            if (!free_any) begin
                                n_res.status = snset_pkg::ST_FULL;
                                n_res.slot   = '0;
                                n_state      = S_EMIT;
                            end else begin
                                p_we = 1'b1; n_we = 1'b1; v_we = 1'b1;
                                p_wa = free_idx; n_wa = free_idx; v_wa = free_idx;
                                if (p_less) begin
                                    n_wd = r_cur;
                                    v_wd = q_prev;
                                    if (r_cur == r_head[r_ch]) begin
                                        head_we    = 1'b1;
                                        head_wdata = {1'b0, free_idx};
                                    end
                                end else begin
                                    n_wd = q_next;
                                    v_wd = r_cur;
                                end
                                n_used[free_idx] = 1'b1;
                                n_ns     = {1'b0, free_idx};
                                n_cnext  = q_next;
                                n_cprev  = q_prev;
                                n_before = p_less;
                                n_res.event_res = snset_pkg::EV_BEGIN;
                                n_res.slot      = free_idx;
                                n_res.is_on     = 1'b1;
                                n_state         = S_LINK;
                            end
                        end else begin
                            n_cur   = q_next;
                            rd_en   = 1'b1;
                            rd_addr = q_next[SW-1:0];
                        end
                    end
                    snset_pkg::CMD_ALL: begin
                        if (out_free) begin
                            n_ovalid = 1'b1;
                            n_out.event_res      = snset_pkg::EV_END;
                            n_out.status         = snset_pkg::ST_OK;
                            n_out.note_pitch_out = q_pitch;
                            n_out.slot           = r_cur[SW-1:0];
                            n_out.is_on          = 1'b0;
                            n_out.last           = !snset_pkg::link_ok(q_next);
                            n_used[r_cur[SW-1:0]] = 1'b0;
                            if (!snset_pkg::link_ok(q_next)) begin
                                head_we    = 1'b1;
                                head_wdata = snset_pkg::LINK_NONE;
                                n_state    = S_IDLE;
                            end else begin
                                n_cur   = q_next;
                                rd_en   = 1'b1;
                                rd_addr = q_next[SW-1:0];
                            end
                        end
                    end
                    default: begin
                        if (hit) begin
                            n_state = S_EMIT;
                            if (r_cmd == snset_pkg::CMD_OFF) begin
                                n_res.event_res = snset_pkg::EV_END;
                                n_used[r_cur[SW-1:0]] = 1'b0;
                                if (snset_pkg::link_ok(q_prev)) begin
                                    n_we = 1'b1;
                                    n_wa = q_prev[SW-1:0];
                                    n_wd = q_next;
                                end else begin
                                    head_we    = 1'b1;
                                    head_wdata = q_next;
                                end
                                if (snset_pkg::link_ok(q_next)) begin
                                    v_we = 1'b1;
                                    v_wa = q_next[SW-1:0];
                                    v_wd = q_prev;
                                end
                            end else begin
                                n_res.is_on = 1'b1;
                            end
                        end else if (!snset_pkg::link_ok(q_next)) begin
                            n_res.status = snset_pkg::ST_NOTFOUND;
                            n_res.slot   = '0;
                            n_state      = S_EMIT;
                        end else begin
                            n_cur   = q_next;
                            rd_en   = 1'b1;
                            rd_addr = q_next[SW-1:0];
                        end
                    end
                endcase
            end
            S_LINK: begin
                if (r_before) begin
                    if (snset_pkg::link_ok(r_cprev)) begin
                        n_we = 1'b1;
                        n_wa = r_cprev[SW-1:0];
                        n_wd = r_ns;
                    end
                    v_we = 1'b1;
                    v_wa = r_cur[SW-1:0];
                    v_wd = r_ns;
                end else begin
                    if (snset_pkg::link_ok(r_cnext)) begin
                        v_we = 1'b1;
                        v_wa = r_cnext[SW-1:0];
                        v_wd = r_ns;
                    end
                    n_we = 1'b1;
                    n_wa = r_cur[SW-1:0];
                    n_wd = r_ns;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out    = r_res;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_ovalid <= 1'b0;
            for (int c = 0; c < snset_pkg::CHANNELS; c++) begin
                r_head[c] <= snset_pkg::LINK_NONE;
            end
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_ovalid <= n_ovalid;
            if (head_we) begin
                r_head[r_ch] <= head_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_cmd <= i_in_data.cmd;
            r_ch  <= i_in_data.channel;
            r_p   <= i_in_data.pitch;
        end
        r_cur    <= n_cur;
        r_ns     <= n_ns;
        r_cnext  <= n_cnext;
        r_cprev  <= n_cprev;
        r_before <= n_before;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

FILE: hw/rtl/snset_ram.sv
// ----------------------------------------------------------------------------
// snset_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module snset_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/snset_checker.sv
// ----------------------------------------------------------------------------
// snset_checker
// Port-level checks for the sorted note set block, bound to the top level.
// ----------------------------------------------------------------------------
module snset_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input snset_pkg::t_res o_out_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_begin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_res == snset_pkg::EV_BEGIN
        |-> o_out_data.is_on && o_out_data.status == snset_pkg::ST_OK
            && o_out_data.last)
        else $error("bad begin result");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == snset_pkg::ST_FULL
        |-> o_out_data.slot == '0 && !o_out_data.is_on
            && o_out_data.event_res == snset_pkg::EV_NONE)
        else $error("bad pool full result");

endmodule

bind sorted_note_set_per_channel snset_checker u_snset_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data(o_out_data)
);

FILE: bench/tb_sorted_note_set_per_channel.sv
// ----------------------------------------------------------------------------
// tb_sorted_note_set_per_channel
// Drives note on/off, all-off and query requests with random burst gaps and
// output stalls, predicts every result with a behavioral note list model and
// checks each whole result against it in order.
// ----------------------------------------------------------------------------
class note_scoreboard;
    localparam int NSLOT = snset_pkg::NOTE_SLOTS;
    localparam int NCH   = snset_pkg::CHANNELS;

    logic signed [15:0] pitch_of [NSLOT];
    int                 nxt [NSLOT];
    int                 prv [NSLOT];
    bit                 used [NSLOT];
    int                 head [NCH];
    snset_pkg::t_res    pending [$];
    int                 mismatches;
    int                 checked;
    int                 ends_seen;

    function new();
        for (int i = 0; i < NSLOT; i++) begin
            used[i] = 0;
            nxt[i] = NSLOT;
            prv[i] = NSLOT;
            pitch_of[i] = '0;
        end
        for (int c = 0; c < NCH; c++) head[c] = NSLOT;
        mismatches = 0;
        checked = 0;
        ends_seen = 0;
    endfunction

    function void push(logic [1:0] ev, logic [1:0] st, logic signed [15:0] p,
                       int s, bit on, bit lst);
        snset_pkg::t_res r;
        r.event_res = ev;
        r.status = st;
        r.note_pitch_out = p;
        r.slot = s[4:0];
        r.is_on = on;
        r.last = lst;
        pending.push_back(r);
    endfunction

    function int locate(int ch, logic signed [15:0] p);
        int s;
        s = head[ch];
        while (s < NSLOT) begin
            if (pitch_of[s] == p) return s;
            s = nxt[s];
        end
        return NSLOT;
    endfunction

    function void note_request(snset_pkg::t_req q);
        int ch, cur, ns, s, k, nx;
        logic signed [15:0] p;
        ch = q.channel;
        p = q.pitch;
        case (q.cmd)
            snset_pkg::CMD_ON: begin
                cur = head[ch];
                while (cur < NSLOT) begin
                    if (pitch_of[cur] == p) begin
                        push(snset_pkg::EV_NONE, snset_pkg::ST_ALREADY, p, cur, 1, 1);
                        return;
                    end
                    if (nxt[cur] >= NSLOT || p < pitch_of[cur]) break;
                    cur = nxt[cur];
                end
                ns = NSLOT;
                for (int i = NSLOT - 1; i >= 0; i--) if (!used[i]) ns = i;
                if (ns == NSLOT) begin
                    push(snset_pkg::EV_NONE, snset_pkg::ST_FULL, p, 0, 0, 1);
                    return;
                end
                used[ns] = 1;
                pitch_of[ns] = p;
                nxt[ns] = NSLOT;
                prv[ns] = NSLOT;
                if (cur >= NSLOT) begin
                    head[ch] = ns;
                end else if (p < pitch_of[cur]) begin
                    if (cur == head[ch]) head[ch] = ns;
                    nxt[ns] = cur;
                    prv[ns] = prv[cur];
                    if (prv[cur] < NSLOT) nxt[prv[cur]] = ns;
                    prv[cur] = ns;
                end else begin
                    prv[ns] = cur;
                    nxt[ns] = nxt[cur];
                    if (nxt[cur] < NSLOT) prv[nxt[cur]] = ns;
                    nxt[cur] = ns;
                end
                push(snset_pkg::EV_BEGIN, snset_pkg::ST_OK, p, ns, 1, 1);
            end
            snset_pkg::CMD_OFF: begin
                s = locate(ch, p);
                if (s >= NSLOT) begin
                    push(snset_pkg::EV_NONE, snset_pkg::ST_NOTFOUND, p, 0, 0, 1);
                    return;
                end
                if (prv[s] < NSLOT) nxt[prv[s]] = nxt[s];
                else head[ch] = nxt[s];
                if (nxt[s] < NSLOT) prv[nxt[s]] = prv[s];
                used[s] = 0;
                push(snset_pkg::EV_END, snset_pkg::ST_OK, p, s, 0, 1);
            end
            snset_pkg::CMD_ALL: begin
                k = 0;
                s = head[ch];
                while (s < NSLOT) begin
                    nx = nxt[s];
                    push(snset_pkg::EV_END, snset_pkg::ST_OK, pitch_of[s], s, 0, 0);
                    k++;
                    used[s] = 0;
                    s = nx;
                end
                head[ch] = NSLOT;
                if (k == 0) push(snset_pkg::EV_NONE, snset_pkg::ST_OK, p, 0, 0, 1);
                else pending[$].last = 1;
            end
            default: begin
                s = locate(ch, p);
                if (s < NSLOT) push(snset_pkg::EV_NONE, snset_pkg::ST_OK, p, s, 1, 1);
                else push(snset_pkg::EV_NONE, snset_pkg::ST_NOTFOUND, p, 0, 0, 1);
            end
        endcase
    endfunction

    function void check_result(snset_pkg::t_res got);
        snset_pkg::t_res want;
        checked++;
        if (got.event_res == snset_pkg::EV_END) ends_seen++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
    endfunction

    function int used_count();
        int n;
        n = 0;
        for (int i = 0; i < NSLOT; i++) n += used[i];
        return n;
    endfunction
endclass

module tb_sorted_note_set_per_channel;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    snset_pkg::t_req   in_data;
    logic              out_valid;
    logic              out_stall;
    snset_pkg::t_res   out_data;

    note_scoreboard sb;
    int             sent;
    int             burst_left;
    bit             stall_free;
    logic signed [15:0] palette [8];

    sorted_note_set_per_channel u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

    // receiver: stall pattern with quiet stretches
    always @(negedge clk) begin
        if (($urandom_range(0, 63) == 0)) stall_free <= ~stall_free;
        out_stall <= stall_free ? 1'b0 : ($urandom_range(0, 2) == 0);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    end

    task automatic send(logic [1:0] cmd, logic [3:0] ch, logic signed [15:0] p);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= '{cmd: cmd, channel: ch, pitch: p};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request('{cmd: cmd, channel: ch, pitch: p});
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(negedge clk);
            guard++;
        end
        repeat (60) @(negedge clk);
    endtask

    function automatic logic signed [15:0] pick_pitch();
        if ($urandom_range(0, 3) != 0) return palette[$urandom_range(0, 7)];
        return 16'($urandom());
    endfunction

    initial begin
        logic [1:0] c;
        int         r;
        sb = new();
        sent = 0;
        burst_left = 0;
        stall_free = 0;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        out_stall = 0;
        palette = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sh0001, 16'sh0100,
                    16'sh3c00, -16'sh0c80, 16'sh5555};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: empty cases, extremes, order, duplicate, full pool
        send(snset_pkg::CMD_ALL, 4'd0, 16'sh1234);
        send(snset_pkg::CMD_QUERY, 4'd0, 16'sh7fff);
        send(snset_pkg::CMD_OFF, 4'd15, 16'sh8000);
        send(snset_pkg::CMD_ON, 4'd0, 16'sh7fff);
        send(snset_pkg::CMD_ON, 4'd0, 16'sh8000);
        send(snset_pkg::CMD_ON, 4'd0, 16'sh0000);
        send(snset_pkg::CMD_ON, 4'd0, 16'sh0000);
        send(snset_pkg::CMD_QUERY, 4'd0, 16'sh8000);
        send(snset_pkg::CMD_OFF, 4'd0, 16'sh0000);
        send(snset_pkg::CMD_ON, 4'd15, -16'sh0001);
        for (int i = 0; i < 30; i++) send(snset_pkg::CMD_ON, 4'd3, 16'(i * 997 - 15000));
        send(snset_pkg::CMD_ON, 4'd3, 16'sh4444);
        send(snset_pkg::CMD_QUERY, 4'd3, 16'(5 * 997 - 15000));
        send(snset_pkg::CMD_ALL, 4'd3, 16'sh0);
        send(snset_pkg::CMD_ALL, 4'd0, 16'sh0);
        send(snset_pkg::CMD_ALL, 4'd15, 16'sh0);
        for (int i = 0; i < 32; i++) send(snset_pkg::CMD_ON, 4'(i % 2), 16'($urandom()));
        send(snset_pkg::CMD_ON, 4'd7, 16'sh0001);
        drain();
        send(snset_pkg::CMD_ALL, 4'd1, 16'sh0);
        send(snset_pkg::CMD_ALL, 4'd0, 16'sh0);

        // random: mostly on/off on a pitch palette, occasional flushes
        while (sent < 370) begin
            r = $urandom_range(0, 99);
            if (r < 45) c = snset_pkg::CMD_ON;
            else if (r < 75) c = snset_pkg::CMD_OFF;
            else if (r < 82) c = snset_pkg::CMD_ALL;
            else c = snset_pkg::CMD_QUERY;
            send(c, ($urandom_range(0, 3) == 0) ? 4'($urandom()) : 4'($urandom_range(0, 2)),
                 pick_pitch());
            if (sent == 250) drain();
        end
        drain();

        $display("requests sent: %0d, results checked: %0d, note ends seen: %0d",
                 sent, sb.checked, sb.ends_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("mismatch count: %0d, left over: %0d", sb.mismatches, sb.pending.size());
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
